// ===== rtl/brp_pkg.sv =====
// Shared types and constants for the 2bpp bitmap row padding removal block.
package brp_pkg;

    // Depth of the result queue in front of the output port.
    localparam int BRP_FIFO_DEPTH = 4;

    // Mask of one 2-bit pixel.
    localparam logic [1:0] BRP_PIX_MASK = 2'h3;

    // One source word.
    typedef struct packed {
        logic [7:0] src_byte;
        logic [7:0] glyph_width;
        logic [7:0] glyph_height;
        logic       glyph_start;
    } brp_in_t;

    // One result word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } brp_out_t;

    // Results made by one source word, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        brp_out_t   first;
        brp_out_t   second;
    } brp_push_t;

endpackage

// ===== rtl/brp_pack.sv =====
// Input register, glyph state and pixel repacking logic.
module brp_pack
    import brp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  brp_in_t   src_data,
    input  logic      room,
    output brp_push_t push
);

    logic       hold_valid_reg;
    logic       hold_valid_next;
    brp_in_t    hold_reg;
    logic       advance;

    logic [5:0] pending_pixels_reg, pending_pixels_next;
    logic [1:0] pending_count_reg, pending_count_next;
    logic [5:0] byte_column_reg, byte_column_next;
    logic [7:0] row_index_reg, row_index_next;
    logic [7:0] width_latched_reg, width_latched_next;
    logic [7:0] height_latched_reg, height_latched_next;

    logic       start;
    logic [7:0] w_eff, h_eff, row_eff;
    logic [5:0] pend_eff, col_eff;
    logic [1:0] cnt_eff;
    logic       active;
    logic [6:0] stride;
    logic       last_col;
    logic       ended;
    logic [8:0] remain;
    logic [2:0] valid_px;
    logic [7:0] new_px;
    logic [13:0] seq;
    logic [2:0] total;
    logic       full;
    logic [2:0] rem_total;
    logic [1:0] rc;
    logic [5:0] rem_mask;
    logic [5:0] rem_px;
    logic [7:0] full_byte;
    logic [7:0] flush_byte;

    // The held word moves on when the queue has room for two results.
    assign advance   = hold_valid_reg && room;
    assign src_stall = hold_valid_reg && !advance;

    // Input register.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (!src_stall)
        begin
            hold_valid_next = src_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            hold_reg <= src_data;
        end
    end

    // A start word restarts the glyph from the fresh sizes.
    always_comb
    begin
        start    = hold_reg.glyph_start;
        w_eff    = start ? hold_reg.glyph_width  : width_latched_reg;
        h_eff    = start ? hold_reg.glyph_height : height_latched_reg;
        row_eff  = start ? 8'd0 : row_index_reg;
        col_eff  = start ? 6'd0 : byte_column_reg;
        cnt_eff  = start ? 2'd0 : pending_count_reg;
        pend_eff = start ? 6'd0 : pending_pixels_reg;
        active   = (w_eff != 8'd0) && (h_eff != 8'd0) && (row_eff < h_eff);
    end

    // Row geometry: bytes per row and valid pixels in this byte.
    always_comb
    begin
        stride   = 7'(({1'b0, w_eff} + 9'd3) >> 2);
        last_col = ({1'b0, col_eff} + 7'd1) >= stride;
        ended    = last_col && (({1'b0, row_eff} + 9'd1) >= {1'b0, h_eff});
        remain   = {1'b0, w_eff} - {1'b0, col_eff, 2'b00};
        valid_px = (remain >= 9'd4) ? 3'd4 : remain[2:0];
    end

    // Join the pending pixels with the valid pixels of this byte.
    always_comb
    begin
        new_px     = hold_reg.src_byte >> (4'd8 - {valid_px, 1'b0});
        seq        = ({8'd0, pend_eff} << {valid_px, 1'b0}) | {6'd0, new_px};
        total      = {1'b0, cnt_eff} + valid_px;
        full       = total >= 3'd4;
        rem_total  = full ? (total - 3'd4) : total;
        rc         = rem_total[1:0];
        full_byte  = 8'(seq >> {rem_total, 1'b0});
        rem_mask   = 6'((7'd1 << {rc, 1'b0}) - 7'd1);
        rem_px     = seq[5:0] & rem_mask;
        flush_byte = 8'({2'b00, rem_px} << (4'd8 - {1'b0, rc, 1'b0}));
    end

    // Results of this word and next state.
    always_comb
    begin
        push                = '0;
        pending_pixels_next = pending_pixels_reg;
        pending_count_next  = pending_count_reg;
        byte_column_next    = byte_column_reg;
        row_index_next      = row_index_reg;
        width_latched_next  = width_latched_reg;
        height_latched_next = height_latched_reg;
        if (advance)
        begin
            width_latched_next  = w_eff;
            height_latched_next = h_eff;
            pending_pixels_next = pend_eff;
            pending_count_next  = cnt_eff;
            byte_column_next    = col_eff;
            row_index_next      = start ? h_eff : row_index_reg;
            if (active)
            begin
                pending_pixels_next = ended ? 6'd0 : rem_px;
                pending_count_next  = ended ? 2'd0 : rc;
                byte_column_next    = last_col ? 6'd0 : (col_eff + 6'd1);
                row_index_next      = last_col ? (row_eff + 8'd1) : row_eff;
                if (full)
                begin
                    push.first.out_byte = full_byte;
                    push.first.out_last = ended && (rc == 2'd0);
                    push.count          = 2'd1;
                end
                if (ended && (rc != 2'd0))
                begin
                    if (full)
                    begin
                        push.second.out_byte = flush_byte;
                        push.second.out_last = 1'b1;
                        push.count           = 2'd2;
                    end
                    else
                    begin
                        push.first.out_byte = flush_byte;
                        push.first.out_last = 1'b1;
                        push.count          = 2'd1;
                    end
                end
            end
        end
    end

    // Glyph state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_pixels_reg <= 6'd0;
            pending_count_reg  <= 2'd0;
            byte_column_reg    <= 6'd0;
            row_index_reg      <= 8'd0;
            width_latched_reg  <= 8'd0;
            height_latched_reg <= 8'd0;
        end
        else
        begin
            pending_pixels_reg <= pending_pixels_next;
            pending_count_reg  <= pending_count_next;
            byte_column_reg    <= byte_column_next;
            row_index_reg      <= row_index_next;
            width_latched_reg  <= width_latched_next;
            height_latched_reg <= height_latched_next;
        end
    end

    // Two results in one step only at glyph end: a full byte, then the marked flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (push.second.out_last && !push.first.out_last))
        else $error("brp_pack: bad ordering of two results");

    // With a pending count of zero, the pending pixels are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_count_reg == 2'd0) |-> (pending_pixels_reg == 6'd0))
        else $error("brp_pack: stale pending pixels");

    // Nothing is produced while no word is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !hold_valid_reg |-> (push.count == 2'd0))
        else $error("brp_pack: result without a source word");

endmodule

// ===== rtl/brp_out_fifo.sv =====
// Small result queue that takes up to two words per cycle and gives one per cycle unless dst stalls.
module brp_out_fifo
    import brp_pkg::*;
#(
    parameter int DEPTH = BRP_FIFO_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  brp_push_t push,
    output logic      room,
    output logic      dst_valid,
    input  logic      dst_stall,
    output brp_out_t  dst_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    brp_out_t      mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_1;
    logic          pop;

    // Pointer after the write pointer, with wrap.
    assign wr_ptr_1 = (wr_ptr_reg == LAST_IDX) ? '0 : (wr_ptr_reg + 1'b1);

    assign room      = count_reg <= CW'(DEPTH - 2);
    assign dst_valid = count_reg != '0;
    assign dst_data  = mem[rd_ptr_reg];
    assign pop       = dst_valid && !dst_stall;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = (wr_ptr_1 == LAST_IDX) ? '0 : (wr_ptr_1 + 1'b1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : (rd_ptr_reg + 1'b1);
        end
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_1] <= push.second;
        end
    end

    // The queue never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("brp_out_fifo: overflow");

    // Pushes only arrive when there was room for them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("brp_out_fifo: push without room");

    // The count follows pushes and pops.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (count_reg ==
            $past(count_reg) + CW'($past(push.count)) - CW'($past(pop))))
        else $error("brp_out_fifo: count mismatch");

endmodule

// ===== rtl/bitmap_row_padding_removal_2bpp.sv =====
// Top level of the 2bpp bitmap row padding removal block.
//
//  channel   dir  handshake              word
//  src       in   src_valid / src_stall  brp_in_t  (source byte, sizes, start)
//  dst       out  dst_valid / dst_stall  brp_out_t (packed byte, last mark)
//
// One source word is taken per cycle while src_stall is low; its results
// reach the output port through the input register and the result queue.
// A word that ends a glyph with a full byte and a partial byte makes two
// results; the queue drains one per cycle unless dst stalls, so src stalls only
// when it is short of room for two. Reset clears the glyph state and empties
// the queue. A stall on dst backs up through the queue into src_stall.
module bitmap_row_padding_removal_2bpp
    import brp_pkg::*;
#(
    parameter int FIFO_DEPTH = BRP_FIFO_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  brp_in_t  src_data,
    output logic     dst_valid,
    input  logic     dst_stall,
    output brp_out_t dst_data
);

    brp_push_t push;
    logic      room;

    // Repacking stage.
    brp_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .room      (room),
        .push      (push)
    );

    // Result queue.
    brp_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule

// ===== tb/brp_repack_checker.sv =====
// Checker that predicts and compares the packed words of the 2bpp row repacker.
module brp_repack_checker
    import brp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    input  logic     src_stall,
    input  brp_in_t  src_data,
    input  logic     dst_valid,
    input  logic     dst_stall,
    input  brp_out_t dst_data,
    output int       errors,
    output int       outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted glyph state, kept apart from the block.
    logic [5:0] pix_hold;
    logic [1:0] pix_count;
    logic [5:0] col_pos;
    logic [7:0] row_pos;
    logic [7:0] width_q;
    logic [7:0] height_q;

    // Packed words still owed by the block, oldest first.
    brp_out_t packed_q[$];
    int       mismatches;

    initial
    begin
        errors = 0;
        outstanding = 0;
        mismatches = 0;
    end

    // Works out the packed words that one accepted source word yields.
    function automatic void repack_word(input brp_in_t w);
        brp_out_t made [2];
        int       stride;
        int       remain;
        int       nvalid;
        int       acc;
        int       cnt;
        int       n;
        int       i;
        int       flush;
        logic     ended;

        n = 0;
        ended = 1'b0;
        if (w.glyph_start)
        begin
            width_q = w.glyph_width;
            height_q = w.glyph_height;
            pix_hold = '0;
            pix_count = '0;
            col_pos = '0;
            row_pos = '0;
            // A glyph with no area leaves the block idle.
            if (width_q == 0 || height_q == 0)
            begin
                row_pos = height_q;
                return;
            end
        end
        // Outside a glyph the word is dropped.
        if (width_q == 0 || row_pos >= height_q)
            return;

        stride = (int'(width_q) + 3) / 4;
        remain = int'(width_q) - 4 * int'(col_pos);
        nvalid = (remain < 4) ? remain : 4;

        // Shift in the pixels that lie inside the glyph width.
        acc = int'(pix_hold);
        cnt = int'(pix_count);
        for (i = 0; i < nvalid; i++)
        begin
            acc = ((acc << 2) | ((int'(w.src_byte) >> (6 - 2 * i)) & int'(BRP_PIX_MASK)))
                  & 'hFF;
            cnt++;
            if (cnt == 4)
            begin
                made[n].out_byte = acc[7:0];
                made[n].out_last = 1'b0;
                n++;
                acc = 0;
                cnt = 0;
            end
        end

        // Advance through the row and the glyph.
        if (int'(col_pos) + 1 >= stride)
        begin
            col_pos = '0;
            row_pos = row_pos + 8'd1;
            ended = (row_pos >= height_q);
        end
        else
        begin
            col_pos = col_pos + 6'd1;
        end

        // At the glyph end the leftover pixels are flushed left-justified.
        if (ended)
        begin
            if (cnt > 0)
            begin
                flush = (acc << (8 - 2 * cnt)) & 'hFF;
                made[n].out_byte = flush[7:0];
                made[n].out_last = 1'b1;
                n++;
            end
            else if (n > 0)
            begin
                made[n - 1].out_last = 1'b1;
            end
            acc = 0;
            cnt = 0;
        end

        pix_hold = acc[5:0];
        pix_count = cnt[1:0];
        for (i = 0; i < n; i++)
            packed_q.push_back(made[i]);
    endfunction

    // Compare each delivered word first, then predict from the accepted source word.
    always @(posedge clk or negedge rst_n)
    begin
        brp_out_t want;

        if (!rst_n)
        begin
            pix_hold = '0;
            pix_count = '0;
            col_pos = '0;
            row_pos = '0;
            width_q = '0;
            height_q = '0;
            packed_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (dst_valid && !dst_stall)
            begin
                if (packed_q.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual out_byte=%h out_last=%b",
                             $time, dst_data.out_byte, dst_data.out_last);
                    mismatches++;
                end
                else
                begin
                    want = packed_q.pop_front();
                    if (dst_data.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte mismatch: expected %h, actual %h",
                                 $time, want.out_byte, dst_data.out_byte);
                        mismatches++;
                    end
                    if (dst_data.out_last !== want.out_last)
                    begin
                        $display("%0t: out_last mismatch: expected %b, actual %b",
                                 $time, want.out_last, dst_data.out_last);
                        mismatches++;
                    end
                end
            end
            if (src_valid && !src_stall)
                repack_word(src_data);
            errors <= mismatches;
            outstanding <= packed_q.size();
        end
    end

endmodule

// ===== tb/tb_bitmap_row_padding_removal_2bpp.sv =====
// Top of the testbench: clock, reset, source and sink traffic, and the verdict.
module tb_bitmap_row_padding_removal_2bpp
    import brp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1450;
    localparam int CYCLE_LIMIT  = 1000000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    brp_in_t  src_data = '0;
    logic     dst_valid;
    logic     dst_stall = 1'b0;
    brp_out_t dst_data;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int glyph_words = 0;
    bit gaps_on = 1'b1;

    // Sink stall pattern state.
    int stall_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    bitmap_row_padding_removal_2bpp uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    brp_repack_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_data    (src_data),
        .dst_valid   (dst_valid),
        .dst_stall   (dst_stall),
        .dst_data    (dst_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sink stalls: phases of none, light and heavy backpressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_left <= $urandom_range(50, 300);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            if (stall_left > 0)
            begin
                dst_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (stall_mode != 0 &&
                     $urandom_range(0, 99) < ((stall_mode == 1) ? 10 : 35))
            begin
                dst_stall <= 1'b1;
                stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(0, 3);
            end
            else
            begin
                dst_stall <= 1'b0;
            end
        end
    end

    // Offer one source word after an optional gap and hold it until taken.
    task automatic send_word(input logic [7:0] b, input logic [7:0] w,
                             input logic [7:0] h, input logic st);
        int      gap;
        int      r;
        brp_in_t word;

        gap = 0;
        if (gaps_on)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 8);
            else
                gap = $urandom_range(15, 40);
        end
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word.src_byte = b;
        word.glyph_width = w;
        word.glyph_height = h;
        word.glyph_start = st;
        src_data <= word;
        src_valid <= 1'b1;
        do @(posedge clk); while (src_stall);
    endtask

    // Send a glyph of w by h pixels, cut short after at most stop words.
    // A negative fill gives random source bytes.
    task automatic send_glyph(input int w, input int h, input int stop, input int fill);
        int stride;
        int total;
        int k;

        stride = (w + 3) / 4;
        total = (w == 0 || h == 0) ? 1 : stride * h;
        if (stop < total)
            total = stop;
        for (k = 0; k < total; k++)
            send_word((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill),
                      (k == 0) ? 8'(w) : 8'($urandom_range(0, 255)),
                      (k == 0) ? 8'(h) : 8'($urandom_range(0, 255)),
                      k == 0);
        glyph_words += total;
    endtask

    // Hold the source until every predicted word has been delivered.
    task automatic wait_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int kind;
        int sz;
        int w;
        int h;
        int k;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle words, empty glyphs, edge widths, two-word glyph end, restart.
        send_word(8'h5A, 8'd7, 8'd3, 1'b0);
        send_glyph(0, 5, 1000, -1);
        send_glyph(3, 0, 1000, -1);
        send_glyph(1, 1, 1000, 8'hFF);
        send_glyph(4, 1, 1000, 8'h00);
        send_glyph(5, 1, 1000, -1);
        send_glyph(3, 3, 1000, -1);
        send_glyph(6, 2, 1000, 8'hFF);
        send_glyph(255, 255, 3, -1);
        send_glyph(2, 2, 1000, -1);
        send_word(8'hA5, 8'd255, 8'd255, 1'b0);
        wait_drained();

        // Random glyphs, mostly well formed, with some noise and cut-off glyphs.
        glyph_words = 0;
        while (glyph_words < RANDOM_WORDS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            sz = $urandom_range(0, 99);
            if (sz < 2)
            begin
                w = $urandom_range(200, 255);
                h = $urandom_range(1, 2);
            end
            else if (sz < 3)
            begin
                w = $urandom_range(1, 4);
                h = $urandom_range(200, 255);
            end
            else
            begin
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 6);
            end
            kind = $urandom_range(0, 99);
            if (kind < 82)
            begin
                send_glyph(w, h, 100000, -1);
            end
            else if (kind < 90)
            begin
                send_glyph(w, h, $urandom_range(1, 8), -1);
            end
            else if (kind < 95)
            begin
                for (k = 0; k < $urandom_range(1, 3); k++)
                    send_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'b0);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_glyph(0, $urandom_range(0, 255), 1, -1);
            end
            else
            begin
                send_glyph($urandom_range(1, 255), 0, 1, -1);
            end
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/brp_pkg.sv
rtl/brp_pack.sv
rtl/brp_out_fifo.sv
rtl/bitmap_row_padding_removal_2bpp.sv
tb/brp_repack_checker.sv
tb/tb_bitmap_row_padding_removal_2bpp.sv
